FILE: hw/rtl/pco_pkg.sv
// ----------------------------------------------------------------------------
// pco_pkg
// shared constants, register indexes and cursor shape lookup for the
// pointer cursor overlay
// ----------------------------------------------------------------------------
package pco_pkg;

   localparam int PIXEL_BITS_DEF = 32;
   localparam int COORD_BITS_DEF = 12;

   localparam int PIX_COORD_BITS = 12;
   localparam int MOVE_BITS      = 16;
   localparam int SIZE_BITS      = 13;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DISPLAY_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DISPLAY_HEIGHT = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CURSOR_FG      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CURSOR_BG      = 4'd3;

   localparam logic [SIZE_BITS-1:0]     RESET_WIDTH  = 13'd640;
   localparam logic [SIZE_BITS-1:0]     RESET_HEIGHT = 13'd480;
   localparam logic [CSR_DATA_BITS-1:0] RESET_FG     = 32'h00FF_FFFF;
   localparam logic [CSR_DATA_BITS-1:0] RESET_BG     = 32'h0000_0000;

   localparam logic REQ_MOTION = 1'b0;
   localparam logic REQ_PIXEL  = 1'b1;
   localparam logic AXIS_X     = 1'b0;
   localparam logic AXIS_Y     = 1'b1;

   localparam int SHAPE_W = 7;
   localparam int SHAPE_H = 15;
   localparam int HOT_X   = 3;
   localparam int HOT_Y   = 7;

   typedef enum logic [1:0] {
      CELL_CLEAR,
      CELL_FG,
      CELL_BG
   } cell_type;

   // rows: top bar, star bar, crossing, stem, crossing, star bar, bottom bar
   function automatic cell_type shape_cell(input logic [3:0] row, input logic [2:0] col);
      cell_type c;
      c = CELL_CLEAR;
      if (row == 4'd0 || row == 4'd14) begin
         c = CELL_BG;
      end else if (row == 4'd1 || row == 4'd13) begin
         c = (col == 3'd0 || col == 3'd6) ? CELL_BG : CELL_FG;
      end else if (row == 4'd2 || row == 4'd12) begin
         c = (col == 3'd3) ? CELL_FG : CELL_BG;
      end else if (row inside {[4'd3:4'd11]}) begin
         case (col)
            3'd2, 3'd4: c = CELL_BG;
            3'd3:       c = CELL_FG;
            default:    c = CELL_CLEAR;
         endcase
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/pointer_cursor_overlay_unit.sv
// rsp valid follows the req accept through the input register, then the result register
// throughput: one word per cycle while rsp is not stalled, motion and pixel words alike
// rsp stall holds the result register and backs up into the input register
// reset: synchronous, active high; display 640x480, fg 0xFFFFFF, bg 0,
// pointer at (320, 240), both pipeline stages empty
// ----------------------------------------------------------------------------
// pointer_cursor_overlay_unit
// hardware pointer cursor: clamped relative motion and a fixed 7x15
// shape composited over the scan-out pixel stream
// ----------------------------------------------------------------------------
module pointer_cursor_overlay_unit #(
   parameter int PIXEL_BITS = pco_pkg::PIXEL_BITS_DEF,
   parameter int COORD_BITS = pco_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic                                req_move_axis,
   input  logic signed [pco_pkg::MOVE_BITS-1:0] req_move_delta,
   input  logic [pco_pkg::PIX_COORD_BITS-1:0]  req_pixel_x,
   input  logic [pco_pkg::PIX_COORD_BITS-1:0]  req_pixel_y,
   input  logic [PIXEL_BITS-1:0]               req_pixel_in,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [PIXEL_BITS-1:0]               rsp_pixel_out,
   output logic [pco_pkg::PIX_COORD_BITS-1:0]  rsp_pointer_x,
   output logic [pco_pkg::PIX_COORD_BITS-1:0]  rsp_pointer_y,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pco_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pco_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pco_pkg::*;

   localparam int EFF_BITS = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
   localparam int PTR_BITS = (COORD_BITS > PIX_COORD_BITS) ? COORD_BITS : PIX_COORD_BITS;
   localparam int SUM_BITS = ((PTR_BITS > MOVE_BITS) ? PTR_BITS : MOVE_BITS) + 2;
   localparam int DIF_BITS = PTR_BITS + 2;

   localparam logic [EFF_BITS-1:0] SIZE_LIMIT = EFF_BITS'(1) << COORD_BITS;
   localparam logic [PTR_BITS-1:0] RESET_COL  = PTR_BITS'(RESET_WIDTH >> 1);
   localparam logic [PTR_BITS-1:0] RESET_ROW  = PTR_BITS'(RESET_HEIGHT >> 1);

   // configuration
   logic [SIZE_BITS-1:0]  width_ff, height_ff;
   logic [PIXEL_BITS-1:0] fg_ff, bg_ff;

   // pointer state
   logic [PTR_BITS-1:0] col_ff, row_ff, col_in, row_in;

   // input register
   logic                      s1_valid_ff;
   logic                      s1_type_ff, s1_axis_ff;
   logic signed [MOVE_BITS-1:0] s1_delta_ff;
   logic [PIX_COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   logic [PIXEL_BITS-1:0]     s1_pixel_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [PIXEL_BITS-1:0]     pixel_out_ff, pixel_out_in;
   logic [PIX_COORD_BITS-1:0] ptr_x_ff, ptr_y_ff;

   logic advance;
   logic load_s1;

   logic [EFF_BITS-1:0] width_eff, height_eff, move_size;
   logic [PTR_BITS-1:0] move_cur, move_new;
   logic signed [SUM_BITS-1:0] move_sum;
   logic in_display;
   logic signed [DIF_BITS-1:0] dx, dy;
   logic in_shape;
   cell_type shape_hit;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign load_s1   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pixel_out_ff;
   assign rsp_pointer_x = ptr_x_ff;
   assign rsp_pointer_y = ptr_y_ff;

   always_comb begin
      width_eff = EFF_BITS'(width_ff);
      if (width_ff == '0) begin
         width_eff = EFF_BITS'(1);
      end else if (EFF_BITS'(width_ff) > SIZE_LIMIT) begin
         width_eff = SIZE_LIMIT;
      end
      height_eff = EFF_BITS'(height_ff);
      if (height_ff == '0) begin
         height_eff = EFF_BITS'(1);
      end else if (EFF_BITS'(height_ff) > SIZE_LIMIT) begin
         height_eff = SIZE_LIMIT;
      end
   end

   // clamped relative motion
   always_comb begin
      move_cur  = (s1_axis_ff == AXIS_X) ? col_ff : row_ff;
      move_size = (s1_axis_ff == AXIS_X) ? width_eff : height_eff;
      move_sum  = $signed(SUM_BITS'(move_cur)) + SUM_BITS'(s1_delta_ff);
      if (move_sum < 0) begin
         move_new = '0;
      end else if (move_sum >= $signed(SUM_BITS'(move_size))) begin
         move_new = PTR_BITS'(move_size - EFF_BITS'(1));
      end else begin
         move_new = PTR_BITS'(move_sum);
      end
      col_in = col_ff;
      row_in = row_ff;
      if (s1_valid_ff && advance && s1_type_ff == REQ_MOTION) begin
         if (s1_axis_ff == AXIS_X) begin
            col_in = move_new;
         end else begin
            row_in = move_new;
         end
      end
   end

   // shape compositing
   always_comb begin
      in_display = (EFF_BITS'(s1_x_ff) < width_eff) && (EFF_BITS'(s1_y_ff) < height_eff);
      dx = $signed(DIF_BITS'(s1_x_ff)) - $signed(DIF_BITS'(col_ff)) + DIF_BITS'(HOT_X);
      dy = $signed(DIF_BITS'(s1_y_ff)) - $signed(DIF_BITS'(row_ff)) + DIF_BITS'(HOT_Y);
      in_shape = (dx >= 0) && (dx < DIF_BITS'(SHAPE_W)) && (dy >= 0) && (dy < DIF_BITS'(SHAPE_H));
      shape_hit = shape_cell(dy[3:0], dx[2:0]);
      pixel_out_in = s1_pixel_ff;
      if (s1_type_ff == REQ_PIXEL && in_display && in_shape) begin
         case (shape_hit)
            CELL_FG: pixel_out_in = fg_ff;
            CELL_BG: pixel_out_in = bg_ff;
            default: pixel_out_in = s1_pixel_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         fg_ff     <= PIXEL_BITS'(RESET_FG);
         bg_ff     <= PIXEL_BITS'(RESET_BG);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DISPLAY_WIDTH:  width_ff  <= csr_wdata[SIZE_BITS-1:0];
            REG_DISPLAY_HEIGHT: height_ff <= csr_wdata[SIZE_BITS-1:0];
            REG_CURSOR_FG:      fg_ff     <= csr_wdata[PIXEL_BITS-1:0];
            REG_CURSOR_BG:      bg_ff     <= csr_wdata[PIXEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= RESET_COL;
         row_ff       <= RESET_ROW;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_type_ff  <= req_type;
         s1_axis_ff  <= req_move_axis;
         s1_delta_ff <= req_move_delta;
         s1_x_ff     <= req_pixel_x;
         s1_y_ff     <= req_pixel_y;
         s1_pixel_ff <= req_pixel_in;
      end
      if (s1_valid_ff && advance) begin
         pixel_out_ff <= pixel_out_in;
         ptr_x_ff     <= col_in[PIX_COORD_BITS-1:0];
         ptr_y_ff     <= row_in[PIX_COORD_BITS-1:0];
      end
   end

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free stage");

   a_col_clamped: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance && s1_type_ff == REQ_MOTION && s1_axis_ff == AXIS_X
      |=> EFF_BITS'(col_ff) < $past(width_eff))
      else $error("pointer column beyond display width");

   a_row_clamped: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance && s1_type_ff == REQ_MOTION && s1_axis_ff == AXIS_Y
      |=> EFF_BITS'(row_ff) < $past(height_eff))
      else $error("pointer row beyond display height");

   a_offscreen_passthrough: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance && !in_display
      |=> pixel_out_ff == $past(s1_pixel_ff))
      else $error("pixel outside display was altered");
`endif

endmodule
